[src/tbmw_pkg.sv]
// shared constants, register codes and state type for the three-body mass window block
package tbmw_pkg;

    // payload widths
    localparam int MOMENTUM_BITS = 18;
    localparam int WEIGHT_BITS   = 16;
    localparam int MASS_W        = 12;
    localparam int WIN_W         = 19;
    localparam int OUT_MASS_W    = 20;
    localparam int HITS_W        = 32;
    localparam int WACC_W        = 48;
    localparam int WSQ_W         = 64;

    // configuration port
    localparam int CFG_W     = 19;
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_PARTICLE_MASS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_LOW    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_HIGH   = 2'd2;

    localparam logic [MASS_W-1:0] PARTICLE_MASS_RST = 12'd511;
    localparam logic [WIN_W-1:0]  WINDOW_LOW_RST    = 19'd103000;
    localparam logic [WIN_W-1:0]  WINDOW_HIGH_RST   = 19'd110000;

    // fixed point
    localparam int E_SHIFT = 18;   // energy radicand scale, Q.8 result after rounding
    localparam int P_SHIFT = 16;   // momentum square into Q.16
    localparam int FRAC_W  = 8;    // fraction bits of the mass root

    // datapath widths
    localparam int TOT_W     = MOMENTUM_BITS + 2;
    localparam int SQ_DIGIT  = 4;
    localparam int SQ_RAW_W  = (MOMENTUM_BITS + 10 > WEIGHT_BITS) ? MOMENTUM_BITS + 10
                                                                  : WEIGHT_BITS;
    localparam int SQ_W      = ((SQ_RAW_W + SQ_DIGIT - 1) / SQ_DIGIT) * SQ_DIGIT;
    localparam int SQ_STEPS  = SQ_W / SQ_DIGIT;
    localparam int RAD_W     = 2 * SQ_W;
    localparam int ROOT_W    = SQ_W;
    localparam int REM_W     = SQ_W + 2;
    localparam int S_W       = 2 * MOMENTUM_BITS + 1;
    localparam int SUM_W     = 2 * MOMENTUM_BITS + 3;
    localparam int CNT_W     = $clog2(ROOT_W + 1);
    localparam int MVAL_W    = ROOT_W - FRAC_W + 1;
    localparam int MCMP_W    = (MVAL_W > OUT_MASS_W) ? MVAL_W : OUT_MASS_W;
    localparam int WCMP_W    = ((ROOT_W > WIN_W + FRAC_W) ? ROOT_W : WIN_W + FRAC_W) + 1;
    localparam int MASS_LIMIT = (1 << (OUT_MASS_W - 1)) - 1;

    localparam int NUM_PART = 3;
    localparam int NUM_AXIS = 3;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MASS,
        ST_MOM,
        ST_ESQRT,
        ST_ESQ,
        ST_PSQ,
        ST_DIFF,
        ST_MSQRT,
        ST_WSQ,
        ST_ACC
    } t_state;

endpackage

[src/three_body_mass_window.sv]
// three-body invariant mass with window test and saturating weight accumulators

// Takes one candidate vertex per input word (three daughter momenta in keV and a
// Q8.8 event weight) and returns one output word: the rounded invariant mass in
// keV (negative when the mass squared is negative, saturated at +-524287), a flag
// for a mass strictly inside the configured window, and the hit count, weight sum
// and squared-weight sum after this candidate. Every multiply is done by one shared
// squaring unit that takes 4 multiplier bits per cycle, and every square root by
// one restoring root unit that settles one result bit per cycle. A candidate needs
// 15 squares and 4 roots, and the input stays stalled while a candidate is in
// work. A finished output word waits in its own register, so a new candidate is
// taken while it is still stalled; the accumulators of the next candidate are
// only touched once that word has left. Configuration registers are to be written
// on the plain write port only while the block is idle; the block itself does not
// enforce this. Writes to an unknown index are dropped.
module three_body_mass_window (
    input  logic                                       i_clk,
    input  logic                                       i_rst_n,
    // configuration
    input  logic                                       i_cfg_we,
    input  logic [tbmw_pkg::CFG_IDX_W-1:0]             i_cfg_index,
    input  logic [tbmw_pkg::CFG_W-1:0]                 i_cfg_data,
    // input word
    input  logic                                       i_in_valid,
    output logic                                       o_in_stall,
    input  logic signed [tbmw_pkg::MOMENTUM_BITS-1:0]  i_first_px,
    input  logic signed [tbmw_pkg::MOMENTUM_BITS-1:0]  i_first_py,
    input  logic signed [tbmw_pkg::MOMENTUM_BITS-1:0]  i_first_pz,
    input  logic signed [tbmw_pkg::MOMENTUM_BITS-1:0]  i_second_px,
    input  logic signed [tbmw_pkg::MOMENTUM_BITS-1:0]  i_second_py,
    input  logic signed [tbmw_pkg::MOMENTUM_BITS-1:0]  i_second_pz,
    input  logic signed [tbmw_pkg::MOMENTUM_BITS-1:0]  i_third_px,
    input  logic signed [tbmw_pkg::MOMENTUM_BITS-1:0]  i_third_py,
    input  logic signed [tbmw_pkg::MOMENTUM_BITS-1:0]  i_third_pz,
    input  logic [tbmw_pkg::WEIGHT_BITS-1:0]           i_event_weight,
    // output word
    output logic                                       o_out_valid,
    input  logic                                       i_out_stall,
    output logic signed [tbmw_pkg::OUT_MASS_W-1:0]     o_mass,
    output logic                                       o_in_window,
    output logic [tbmw_pkg::HITS_W-1:0]                o_hit_count,
    output logic [tbmw_pkg::WACC_W-1:0]                o_weight_total,
    output logic [tbmw_pkg::WSQ_W-1:0]                 o_weight_sq_total
);

    // configuration registers
    logic [tbmw_pkg::MASS_W-1:0] r_particle_mass;
    logic [tbmw_pkg::WIN_W-1:0]  r_window_low;
    logic [tbmw_pkg::WIN_W-1:0]  r_window_high;

    // sequencer
    tbmw_pkg::t_state           r_state, n_state;
    logic [1:0]                 r_part, n_part;   // daughter being worked on
    logic [1:0]                 r_idx, n_idx;     // axis being worked on
    logic [tbmw_pkg::CNT_W-1:0] r_cnt, n_cnt;     // zero is the load cycle of a unit

    // latched candidate
    logic signed [tbmw_pkg::MOMENTUM_BITS-1:0] r_mom [tbmw_pkg::NUM_PART][tbmw_pkg::NUM_AXIS];
    logic signed [tbmw_pkg::TOT_W-1:0]         r_tot [tbmw_pkg::NUM_AXIS];
    logic [tbmw_pkg::WEIGHT_BITS-1:0]          r_weight;

    // partial results
    logic [2*tbmw_pkg::MASS_W-1:0] r_msq;   // daughter mass squared
    logic [tbmw_pkg::SUM_W-1:0]    r_sum;   // running m^2+p^2, later |P|^2
    logic [tbmw_pkg::ROOT_W-1:0]   r_esum;  // energy sum, Q.8 keV
    logic [tbmw_pkg::RAD_W-1:0]    r_e2;    // energy sum squared
    logic                          r_neg;   // mass squared below zero
    logic signed [tbmw_pkg::OUT_MASS_W-1:0] r_res_mass;
    logic                          r_res_in;

    // shared squaring unit, one 4-bit digit of the multiplier per cycle
    logic [tbmw_pkg::RAD_W-1:0]    r_sq_p;
    logic [tbmw_pkg::SQ_W-1:0]     r_sq_m;
    logic [tbmw_pkg::SQ_W+tbmw_pkg::SQ_DIGIT-1:0] sq_hi;
    logic [tbmw_pkg::RAD_W-1:0]    sq_next;
    logic [tbmw_pkg::SQ_W-1:0]     sq_opnd;
    logic                          sq_state, sq_load, sq_run, sq_done;

    // shared root unit, one result bit per cycle
    logic [tbmw_pkg::RAD_W-1:0]    r_rad;
    logic [tbmw_pkg::REM_W-1:0]    r_rem;
    logic [tbmw_pkg::ROOT_W-1:0]   r_root;
    logic [tbmw_pkg::REM_W+1:0]    rt_t, rt_trial, rt_diff;
    logic                          rt_ge;
    logic [tbmw_pkg::RAD_W-1:0]    rt_opnd;
    logic                          rt_state, rt_load, rt_run, rt_done;

    // accumulators and output word
    logic [tbmw_pkg::HITS_W-1:0]   r_hits;
    logic [tbmw_pkg::WACC_W-1:0]   r_wacc;
    logic [tbmw_pkg::WSQ_W-1:0]    r_wsq;
    logic                          r_o_valid;
    logic signed [tbmw_pkg::OUT_MASS_W-1:0] r_o_mass;
    logic                          r_o_in;
    logic [tbmw_pkg::WACC_W:0]     wacc_add;
    logic [tbmw_pkg::WSQ_W:0]      wsq_add;

    logic                          in_acc, out_free;

    // combinational helpers
    logic [tbmw_pkg::MOMENTUM_BITS-1:0] mom_sel, mom_mag;
    logic [tbmw_pkg::TOT_W-1:0]         tot_sel, tot_mag;
    logic [tbmw_pkg::ROOT_W-1:0]        e_round, esum_fin;
    logic [tbmw_pkg::SUM_W-1:0]         sum_p;
    logic [tbmw_pkg::RAD_W-1:0]         p2_sh, m2_pos, m2_neg;
    logic                               m2_lt;
    logic [tbmw_pkg::ROOT_W:0]          k_round;
    logic [tbmw_pkg::MCMP_W-1:0]        mval, msat;
    logic [tbmw_pkg::OUT_MASS_W-1:0]    mass_mag;
    logic [tbmw_pkg::WCMP_W-1:0]        k_x, low_x, high_x;
    logic                               in_win;

    assign in_acc   = i_in_valid && !o_in_stall;
    assign out_free = !r_o_valid || !i_out_stall;

    // ---------------------------------------------------------------- configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_particle_mass <= tbmw_pkg::PARTICLE_MASS_RST;
            r_window_low    <= tbmw_pkg::WINDOW_LOW_RST;
            r_window_high   <= tbmw_pkg::WINDOW_HIGH_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                tbmw_pkg::CFG_PARTICLE_MASS: r_particle_mass <= i_cfg_data[tbmw_pkg::MASS_W-1:0];
                tbmw_pkg::CFG_WINDOW_LOW:    r_window_low    <= i_cfg_data[tbmw_pkg::WIN_W-1:0];
                tbmw_pkg::CFG_WINDOW_HIGH:   r_window_high   <= i_cfg_data[tbmw_pkg::WIN_W-1:0];
                default: ;  // unknown index, write dropped
            endcase
        end
    end

    // ---------------------------------------------------------------- sequencer
    assign sq_done = (r_cnt == tbmw_pkg::CNT_W'(tbmw_pkg::SQ_STEPS));
    assign rt_done = (r_cnt == tbmw_pkg::CNT_W'(tbmw_pkg::ROOT_W));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= tbmw_pkg::ST_IDLE;
            r_part  <= '0;
            r_idx   <= '0;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_part  <= n_part;
            r_idx   <= n_idx;
            r_cnt   <= n_cnt;
        end
    end

    always_comb begin
        n_state    = r_state;
        n_part     = r_part;
        n_idx      = r_idx;
        n_cnt      = r_cnt + 1'b1;
        o_in_stall = 1'b1;
        unique case (r_state)
            tbmw_pkg::ST_IDLE: begin
                o_in_stall = 1'b0;
                n_cnt      = '0;
                n_part     = '0;
                n_idx      = '0;
                if (i_in_valid) begin
                    n_state = tbmw_pkg::ST_MASS;
                end
            end
            tbmw_pkg::ST_MASS: begin
                if (sq_done) begin
                    n_state = tbmw_pkg::ST_MOM;
                    n_cnt   = '0;
                end
            end
            tbmw_pkg::ST_MOM: begin
                if (sq_done) begin
                    n_cnt = '0;
                    if (r_idx == 2'(tbmw_pkg::NUM_AXIS - 1)) begin
                        n_state = tbmw_pkg::ST_ESQRT;
                    end else begin
                        n_idx = r_idx + 1'b1;
                    end
                end
            end
            tbmw_pkg::ST_ESQRT: begin
                if (rt_done) begin
                    n_cnt = '0;
                    n_idx = '0;
                    if (r_part == 2'(tbmw_pkg::NUM_PART - 1)) begin
                        n_state = tbmw_pkg::ST_ESQ;
                    end else begin
                        n_state = tbmw_pkg::ST_MOM;
                        n_part  = r_part + 1'b1;
                    end
                end
            end
            tbmw_pkg::ST_ESQ: begin
                if (sq_done) begin
                    n_state = tbmw_pkg::ST_PSQ;
                    n_cnt   = '0;
                    n_idx   = '0;
                end
            end
            tbmw_pkg::ST_PSQ: begin
                if (sq_done) begin
                    n_cnt = '0;
                    if (r_idx == 2'(tbmw_pkg::NUM_AXIS - 1)) begin
                        n_state = tbmw_pkg::ST_DIFF;
                    end else begin
                        n_idx = r_idx + 1'b1;
                    end
                end
            end
            tbmw_pkg::ST_DIFF: begin
                n_state = tbmw_pkg::ST_MSQRT;
                n_cnt   = '0;
            end
            tbmw_pkg::ST_MSQRT: begin
                if (rt_done) begin
                    n_state = tbmw_pkg::ST_WSQ;
                    n_cnt   = '0;
                end
            end
            tbmw_pkg::ST_WSQ: begin
                if (sq_done) begin
                    n_state = tbmw_pkg::ST_ACC;
                    n_cnt   = '0;
                end
            end
            tbmw_pkg::ST_ACC: begin
                n_cnt = '0;
                // hold until the output register can take the word
                if (out_free) begin
                    n_state = tbmw_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = tbmw_pkg::ST_IDLE;
                n_cnt   = '0;
            end
        endcase
    end

    // which unit the current state drives
    always_comb begin
        sq_state = 1'b0;
        rt_state = 1'b0;
        unique case (r_state) inside
            tbmw_pkg::ST_MASS, tbmw_pkg::ST_MOM, tbmw_pkg::ST_ESQ,
            tbmw_pkg::ST_PSQ, tbmw_pkg::ST_WSQ:   sq_state = 1'b1;
            tbmw_pkg::ST_ESQRT, tbmw_pkg::ST_MSQRT: rt_state = 1'b1;
            default: ;
        endcase
    end

    assign sq_load = sq_state && (r_cnt == '0);
    assign sq_run  = sq_state && (r_cnt != '0);
    assign rt_load = rt_state && (r_cnt == '0);
    assign rt_run  = rt_state && (r_cnt != '0);

    // ---------------------------------------------------------------- operand selection
    always_comb begin
        mom_sel = r_mom[r_part][r_idx];
        mom_mag = mom_sel[tbmw_pkg::MOMENTUM_BITS-1] ? (~mom_sel + 1'b1) : mom_sel;
        tot_sel = r_tot[r_idx];
        tot_mag = tot_sel[tbmw_pkg::TOT_W-1] ? (~tot_sel + 1'b1) : tot_sel;

        // energy rounded to nearest Q.8 from the root of s * 2^18
        e_round  = tbmw_pkg::ROOT_W'(({1'b0, r_root} + 1'b1) >> 1);
        esum_fin = r_esum + e_round;

        sum_p = r_sum + r_sq_p[tbmw_pkg::SUM_W-1:0];

        // |P|^2 in Q.16 against E^2
        p2_sh  = {{(tbmw_pkg::RAD_W - tbmw_pkg::SUM_W - tbmw_pkg::P_SHIFT){1'b0}},
                  r_sum, {tbmw_pkg::P_SHIFT{1'b0}}};
        m2_lt  = (r_e2 < p2_sh);
        m2_pos = r_e2 - p2_sh;
        m2_neg = p2_sh - r_e2;

        sq_opnd = '0;
        rt_opnd = '0;
        case (r_state)
            tbmw_pkg::ST_MASS: sq_opnd = tbmw_pkg::SQ_W'(r_particle_mass);
            tbmw_pkg::ST_MOM:  sq_opnd = tbmw_pkg::SQ_W'(mom_mag);
            tbmw_pkg::ST_ESQ:  sq_opnd = esum_fin;
            tbmw_pkg::ST_PSQ:  sq_opnd = tbmw_pkg::SQ_W'(tot_mag);
            tbmw_pkg::ST_WSQ:  sq_opnd = tbmw_pkg::SQ_W'(r_weight);
            tbmw_pkg::ST_ESQRT: begin
                rt_opnd = {{(tbmw_pkg::RAD_W - tbmw_pkg::S_W - tbmw_pkg::E_SHIFT){1'b0}},
                           sum_p[tbmw_pkg::S_W-1:0], {tbmw_pkg::E_SHIFT{1'b0}}};
            end
            tbmw_pkg::ST_MSQRT: rt_opnd = m2_lt ? m2_neg : m2_pos;
            default: ;
        endcase
    end

    // ---------------------------------------------------------------- arithmetic units
    always_comb begin
        sq_hi   = (tbmw_pkg::SQ_W + tbmw_pkg::SQ_DIGIT)'(r_sq_p[tbmw_pkg::RAD_W-1:tbmw_pkg::SQ_W])
                + r_sq_m * r_sq_p[tbmw_pkg::SQ_DIGIT-1:0];
        sq_next = {sq_hi, r_sq_p[tbmw_pkg::SQ_W-1:tbmw_pkg::SQ_DIGIT]};

        rt_t     = {r_rem, r_rad[tbmw_pkg::RAD_W-1 -: 2]};
        rt_trial = {2'b00, r_root, 2'b01};
        rt_ge    = (rt_t >= rt_trial);
        rt_diff  = rt_t - rt_trial;
    end

    always_ff @(posedge i_clk) begin
        if (sq_load) begin
            r_sq_p <= {{(tbmw_pkg::RAD_W - tbmw_pkg::SQ_W){1'b0}}, sq_opnd};
            r_sq_m <= sq_opnd;
        end else if (sq_run) begin
            r_sq_p <= sq_next;
        end

        if (rt_load) begin
            r_rad  <= rt_opnd;
            r_rem  <= '0;
            r_root <= '0;
        end else if (rt_run) begin
            r_rad  <= {r_rad[tbmw_pkg::RAD_W-3:0], 2'b00};
            r_rem  <= rt_ge ? rt_diff[tbmw_pkg::REM_W-1:0] : rt_t[tbmw_pkg::REM_W-1:0];
            r_root <= {r_root[tbmw_pkg::ROOT_W-2:0], rt_ge};
        end
    end

    // ---------------------------------------------------------------- mass and window
    always_comb begin
        k_round  = {1'b0, r_root} + (tbmw_pkg::ROOT_W + 1)'(1 << (tbmw_pkg::FRAC_W - 1));
        mval     = tbmw_pkg::MCMP_W'(k_round[tbmw_pkg::ROOT_W:tbmw_pkg::FRAC_W]);
        msat     = (mval > tbmw_pkg::MCMP_W'(tbmw_pkg::MASS_LIMIT))
                 ? tbmw_pkg::MCMP_W'(tbmw_pkg::MASS_LIMIT) : mval;
        mass_mag = msat[tbmw_pkg::OUT_MASS_W-1:0];

        // strict bounds on the exact mass squared, via root and remainder
        k_x    = tbmw_pkg::WCMP_W'(r_root);
        low_x  = tbmw_pkg::WCMP_W'({r_window_low, {tbmw_pkg::FRAC_W{1'b0}}});
        high_x = tbmw_pkg::WCMP_W'({r_window_high, {tbmw_pkg::FRAC_W{1'b0}}});
        in_win = !r_neg
              && ((k_x > low_x) || ((k_x == low_x) && (r_rem != '0)))
              && (k_x < high_x);
    end

    // ---------------------------------------------------------------- datapath registers
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_mom[0][0] <= i_first_px;
            r_mom[0][1] <= i_first_py;
            r_mom[0][2] <= i_first_pz;
            r_mom[1][0] <= i_second_px;
            r_mom[1][1] <= i_second_py;
            r_mom[1][2] <= i_second_pz;
            r_mom[2][0] <= i_third_px;
            r_mom[2][1] <= i_third_py;
            r_mom[2][2] <= i_third_pz;
            r_tot[0] <= tbmw_pkg::TOT_W'(i_first_px) + tbmw_pkg::TOT_W'(i_second_px)
                      + tbmw_pkg::TOT_W'(i_third_px);
            r_tot[1] <= tbmw_pkg::TOT_W'(i_first_py) + tbmw_pkg::TOT_W'(i_second_py)
                      + tbmw_pkg::TOT_W'(i_third_py);
            r_tot[2] <= tbmw_pkg::TOT_W'(i_first_pz) + tbmw_pkg::TOT_W'(i_second_pz)
                      + tbmw_pkg::TOT_W'(i_third_pz);
            r_weight <= i_event_weight;
        end

        // each load cycle takes the result the unit finished just before
        if (r_cnt == '0) begin
            case (r_state)
                tbmw_pkg::ST_MOM: begin
                    if (r_idx == '0) begin
                        if (r_part == '0) begin
                            r_msq  <= r_sq_p[2*tbmw_pkg::MASS_W-1:0];
                            r_sum  <= tbmw_pkg::SUM_W'(r_sq_p[2*tbmw_pkg::MASS_W-1:0]);
                            r_esum <= '0;
                        end else begin
                            r_sum  <= tbmw_pkg::SUM_W'(r_msq);
                            r_esum <= esum_fin;
                        end
                    end else begin
                        r_sum <= sum_p;
                    end
                end
                tbmw_pkg::ST_PSQ: begin
                    if (r_idx == '0) begin
                        r_e2 <= r_sq_p;
                    end else if (r_idx == 2'd1) begin
                        r_sum <= r_sq_p[tbmw_pkg::SUM_W-1:0];
                    end else begin
                        r_sum <= sum_p;
                    end
                end
                tbmw_pkg::ST_DIFF:  r_sum <= sum_p;
                tbmw_pkg::ST_MSQRT: r_neg <= m2_lt;
                tbmw_pkg::ST_WSQ: begin
                    r_res_mass <= r_neg ? -$signed(mass_mag) : $signed(mass_mag);
                    r_res_in   <= in_win;
                end
                default: ;
            endcase
        end

        if ((r_state == tbmw_pkg::ST_ACC) && out_free) begin
            r_o_mass <= r_res_mass;
            r_o_in   <= r_res_in;
        end
    end

    // ---------------------------------------------------------------- accumulators
    always_comb begin
        wacc_add = {1'b0, r_wacc} + (tbmw_pkg::WACC_W + 1)'(r_weight);
        wsq_add  = {1'b0, r_wsq} + (tbmw_pkg::WSQ_W + 1)'(r_sq_p);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hits    <= '0;
            r_wacc    <= '0;
            r_wsq     <= '0;
            r_o_valid <= 1'b0;
        end else begin
            if ((r_state == tbmw_pkg::ST_ACC) && out_free) begin
                r_o_valid <= 1'b1;
                if (r_res_in) begin
                    if (r_hits != '1) begin
                        r_hits <= r_hits + 1'b1;
                    end
                    r_wacc <= wacc_add[tbmw_pkg::WACC_W] ? '1 : wacc_add[tbmw_pkg::WACC_W-1:0];
                    r_wsq  <= wsq_add[tbmw_pkg::WSQ_W] ? '1 : wsq_add[tbmw_pkg::WSQ_W-1:0];
                end
            end else if (!i_out_stall) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid       = r_o_valid;
    assign o_mass            = r_o_mass;
    assign o_in_window       = r_o_in;
    assign o_hit_count       = r_hits;
    assign o_weight_total    = r_wacc;
    assign o_weight_sq_total = r_wsq;

endmodule
